/* design/slp_pkg.sv */
// ----------------------------------------------------------------------------
// slp_pkg
// Shared widths, constants, CORDIC arctangent table and stage word types for
// the stereonet line projection pipeline.
// ----------------------------------------------------------------------------
package slp_pkg;

    localparam int ANGLE_BITS      = 16;
    localparam int COORD_FRAC_BITS = 14;
    localparam int OUT_W           = COORD_FRAC_BITS + 2;

    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam int CW           = 33;      // CORDIC datapath, 32-bit turn + guard
    localparam int TRIG_W       = 32;      // signed Q30 in [-1, 1]
    localparam int UTRIG_W      = 31;      // unsigned Q30 in [0, 1]
    localparam int DEN_W        = 32;
    localparam int DIG_STEPS    = 31;      // quotient / root bits
    localparam int ROOT_W       = 31;
    localparam int REM_W        = 33;
    localparam int RAD_W        = 62;
    localparam int PROD_W       = 64;
    localparam int RND_SH       = 60 - COORD_FRAC_BITS;

    localparam logic signed [CW-1:0] GAIN_INV = 33'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30  = 33'sh040000000;

    // register map
    localparam int             REG_IDX_W = 1;
    localparam int             PADDR_W   = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_KIND = 1'b0;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } t_rot;

    typedef struct packed {
        logic [DEN_W-1:0]     rem;
        logic [DEN_W-1:0]     den;
        logic [DIG_STEPS-1:0] nlo;
        logic [ROOT_W-1:0]    quo;
    } t_div;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } t_sqr;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [CW-1:0] atan_step(input logic [STEP_W-1:0] i);
        logic signed [CW-1:0] a;
        case (i)
            5'd0:    a = 33'sh020000000;
            5'd1:    a = 33'sh012E4051E;
            5'd2:    a = 33'sh009FB385B;
            5'd3:    a = 33'sh0051111D4;
            5'd4:    a = 33'sh0028B0D43;
            5'd5:    a = 33'sh00145D7E1;
            5'd6:    a = 33'sh000A2F61E;
            5'd7:    a = 33'sh000517C55;
            5'd8:    a = 33'sh00028BE53;
            5'd9:    a = 33'sh000145F2F;
            5'd10:   a = 33'sh0000A2F98;
            5'd11:   a = 33'sh0000517CC;
            5'd12:   a = 33'sh000028BE6;
            5'd13:   a = 33'sh0000145F3;
            5'd14:   a = 33'sh00000A2F9;
            5'd15:   a = 33'sh00000517C;
            5'd16:   a = 33'sh0000028BE;
            5'd17:   a = 33'sh00000145F;
            5'd18:   a = 33'sh000000A2F;
            5'd19:   a = 33'sh000000517;
            5'd20:   a = 33'sh00000028B;
            5'd21:   a = 33'sh000000145;
            5'd22:   a = 33'sh0000000A2;
            5'd23:   a = 33'sh000000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* design/stereonet_line_projection_unit.sv */
// ----------------------------------------------------------------------------
// stereonet_line_projection_unit
// Lower-hemisphere stereonet projection of a line (trend, plunge) to x/y.
// Pipeline: 59 register stages (fold, 24 CORDIC cells, clamp, 31 divide/root
//   cells, multiply, round); o_valid follows the same chain of valid bits.
// Throughput: one word per cycle; the whole chain advances together and
//   holds while a finished word waits at the output.
// Reset: synchronous active-low; clears valid bits and projection_kind.
// ----------------------------------------------------------------------------
module stereonet_line_projection_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [slp_pkg::ANGLE_BITS-1:0]         i_line_trend,
    input  logic signed [slp_pkg::ANGLE_BITS-1:0]  i_line_plunge,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [slp_pkg::OUT_W-1:0]       o_point_x,
    output logic signed [slp_pkg::OUT_W-1:0]       o_point_y,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [slp_pkg::PADDR_W-1:0]            paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import slp_pkg::*;

    localparam logic [ANGLE_BITS-1:0] HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS:0]   QUARTER = (ANGLE_BITS + 1)'(1) << (ANGLE_BITS - 2);
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (RND_SH - 1);

    function automatic logic signed [TRIG_W-1:0] clamp_sym(input logic signed [CW-1:0] v);
        logic signed [TRIG_W-1:0] c;
        if (v > ONE_Q30) c = TRIG_W'(ONE_Q30);
        else if (v < -ONE_Q30) c = -TRIG_W'(ONE_Q30);
        else c = v[TRIG_W-1:0];
        return c;
    endfunction

    function automatic logic [UTRIG_W-1:0] clamp_pos(input logic signed [CW-1:0] v);
        logic [UTRIG_W-1:0] c;
        if (v > ONE_Q30) c = UTRIG_W'(ONE_Q30);
        else if (v[CW-1]) c = '0;
        else c = v[UTRIG_W-1:0];
        return c;
    endfunction

    function automatic t_rot rot_init(input logic [31:0] a);
        t_rot        r;
        logic        f;
        logic [31:0] a2;
        f = a[31] ^ a[30];
        a2 = {a[31] ^ f, a[30:0]};
        r.x = GAIN_INV;
        r.y = '0;
        r.z = $signed({a2[31], a2});
        r.flip = f;
        return r;
    endfunction

    logic w_en;
    logic r_kind;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= 1'b0;
        end else if (psel && penable && pwrite && paddr[PADDR_W-1:2] == REG_KIND) begin
            r_kind <= pwdata[0];
        end
    end
    assign prdata = (paddr[PADDR_W-1:2] == REG_KIND) ? {31'd0, r_kind} : 32'd0;

    // ---------------- fold ----------------
    logic                      w_neg;
    logic [ANGLE_BITS-1:0]     w_trend;
    logic [ANGLE_BITS:0]       w_pabs;
    logic [ANGLE_BITS-2:0]     w_psat;

    assign w_neg   = i_line_plunge[ANGLE_BITS-1];
    assign w_trend = w_neg ? i_line_trend + HALF : i_line_trend;
    assign w_pabs  = w_neg ? (ANGLE_BITS + 1)'(-(ANGLE_BITS + 1)'(i_line_plunge))
                           : (ANGLE_BITS + 1)'(i_line_plunge);
    assign w_psat  = (w_pabs > QUARTER) ? QUARTER[ANGLE_BITS-2:0] : w_pabs[ANGLE_BITS-2:0];

    t_rot r_t0, r_p0;
    logic r_v0;

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t0 <= rot_init({w_trend, (32 - ANGLE_BITS)'(0)});
            r_p0 <= rot_init({1'b0, w_psat, (32 - ANGLE_BITS)'(0)});
        end
    end

    // ---------------- CORDIC rows ----------------
    t_rot w_tc [CORDIC_STEPS+1];
    t_rot w_pc [CORDIC_STEPS+1];
    logic [CORDIC_STEPS-1:0] r_vc;

    assign w_tc[0] = r_t0;
    assign w_pc[0] = r_p0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        slp_cordic_cell u_t (
            .i_clk (i_clk), .i_en (w_en), .i_step (STEP_W'(g)),
            .i_d   (w_tc[g]), .o_q (w_tc[g+1])
        );
        slp_cordic_cell u_p (
            .i_clk (i_clk), .i_en (w_en), .i_step (STEP_W'(g)),
            .i_d   (w_pc[g]), .o_q (w_pc[g+1])
        );
    end

    // ---------------- clamp and operand setup ----------------
    t_rot                     w_tl, w_pl;
    logic signed [CW-1:0]     w_tx, w_ty, w_px, w_py;
    logic [UTRIG_W-1:0]       w_pcos, w_psin;
    logic [DEN_W-1:0]         w_den;
    logic [60:0]              w_num;

    assign w_tl = w_tc[CORDIC_STEPS];
    assign w_pl = w_pc[CORDIC_STEPS];
    assign w_tx = w_tl.flip ? -w_tl.x : w_tl.x;
    assign w_ty = w_tl.flip ? -w_tl.y : w_tl.y;
    assign w_px = w_pl.flip ? -w_pl.x : w_pl.x;
    assign w_py = w_pl.flip ? -w_pl.y : w_pl.y;
    assign w_pcos = clamp_pos(w_px);
    assign w_psin = clamp_pos(w_py);
    assign w_den  = DEN_W'(ONE_Q30) + DEN_W'(w_psin);
    // rounded quotient: add half the divisor up front
    assign w_num  = {w_pcos, 30'd0} + 61'(w_den >> 1);

    t_div                     r_d0;
    t_sqr                     r_s0;
    logic signed [TRIG_W-1:0] r_ts0, r_tc0;
    logic                     r_vp;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d0.rem  <= DEN_W'(w_num[60:DIG_STEPS]);
            r_d0.den  <= w_den;
            r_d0.nlo  <= w_num[DIG_STEPS-1:0];
            r_d0.quo  <= '0;
            r_s0.rem  <= '0;
            r_s0.root <= '0;
            r_s0.rad  <= {1'b0, UTRIG_W'(UTRIG_W'(ONE_Q30) - w_psin), 30'd0};
            r_ts0     <= clamp_sym(w_ty);
            r_tc0     <= clamp_sym(w_tx);
        end
    end

    // ---------------- divide / root rows ----------------
    t_div                     w_dc [DIG_STEPS+1];
    t_sqr                     w_sc [DIG_STEPS+1];
    logic signed [TRIG_W-1:0] r_ts [DIG_STEPS];
    logic signed [TRIG_W-1:0] r_tc [DIG_STEPS];
    logic [DIG_STEPS-1:0]     r_vd;

    assign w_dc[0] = r_d0;
    assign w_sc[0] = r_s0;

    for (genvar g = 0; g < DIG_STEPS; g++) begin : g_digit
        slp_div_cell u_d (
            .i_clk (i_clk), .i_en (w_en), .i_d (w_dc[g]), .o_q (w_dc[g+1])
        );
        slp_sqrt_cell u_s (
            .i_clk (i_clk), .i_en (w_en), .i_d (w_sc[g]), .o_q (w_sc[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ts[0] <= r_ts0;
            r_tc[0] <= r_tc0;
            for (int k = 1; k < DIG_STEPS; k++) begin
                r_ts[k] <= r_ts[k-1];
                r_tc[k] <= r_tc[k-1];
            end
        end
    end

    // ---------------- multiply ----------------
    logic [ROOT_W-1:0]        w_r;
    logic signed [PROD_W-1:0] r_mx, r_my;
    logic                     r_vm;

    assign w_r = r_kind ? w_sc[DIG_STEPS].root : w_dc[DIG_STEPS].quo;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mx <= PROD_W'($signed({1'b0, w_r})) * PROD_W'(r_ts[DIG_STEPS-1]);
            r_my <= PROD_W'($signed({1'b0, w_r})) * PROD_W'(r_tc[DIG_STEPS-1]);
        end
    end

    // ---------------- round and output ----------------
    logic signed [PROD_W-1:0] w_rx, w_ry;
    logic signed [OUT_W-1:0]  r_ox, r_oy;
    logic                     r_ov;

    assign w_rx = (r_mx + RND_HALF) >>> RND_SH;
    assign w_ry = (r_my + RND_HALF) >>> RND_SH;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ox <= w_rx[OUT_W-1:0];
            r_oy <= w_ry[OUT_W-1:0];
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_vc <= '0;
            r_vp <= 1'b0;
            r_vd <= '0;
            r_vm <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_valid;
            r_vc <= {r_vc[CORDIC_STEPS-2:0], r_v0};
            r_vp <= r_vc[CORDIC_STEPS-1];
            r_vd <= {r_vd[DIG_STEPS-2:0], r_vp};
            r_vm <= r_vd[DIG_STEPS-1];
            r_ov <= r_vm;
        end
    end

    assign o_valid   = r_ov;
    assign o_point_x = r_ox;
    assign o_point_y = r_oy;

endmodule

/* design/slp_cordic_cell.sv */
// ----------------------------------------------------------------------------
// slp_cordic_cell
// One rotation-mode CORDIC micro-rotation with its output register.
// ----------------------------------------------------------------------------
module slp_cordic_cell (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [slp_pkg::STEP_W-1:0]    i_step,
    input  slp_pkg::t_rot                 i_d,
    output slp_pkg::t_rot                 o_q
);
    import slp_pkg::*;

    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;
    t_rot                 n_q;
    t_rot                 r_q;

    assign w_xs = i_d.x >>> i_step;
    assign w_ys = i_d.y >>> i_step;

    always_comb begin
        n_q.flip = i_d.flip;
        if (!i_d.z[CW-1]) begin
            n_q.x = i_d.x - w_ys;
            n_q.y = i_d.y + w_xs;
            n_q.z = i_d.z - atan_step(i_step);
        end else begin
            n_q.x = i_d.x + w_ys;
            n_q.y = i_d.y - w_xs;
            n_q.z = i_d.z + atan_step(i_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

/* design/slp_div_cell.sv */
// ----------------------------------------------------------------------------
// slp_div_cell
// One restoring-division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module slp_div_cell (
    input  logic          i_clk,
    input  logic          i_en,
    input  slp_pkg::t_div i_d,
    output slp_pkg::t_div o_q
);
    import slp_pkg::*;

    logic [DEN_W:0] w_t;
    logic [DEN_W:0] w_diff;
    logic           w_ge;
    t_div           n_q;
    t_div           r_q;

    assign w_t    = {i_d.rem, i_d.nlo[DIG_STEPS-1]};
    assign w_diff = w_t - {1'b0, i_d.den};
    assign w_ge   = (w_t >= {1'b0, i_d.den});

    always_comb begin
        n_q.den = i_d.den;
        n_q.rem = w_ge ? w_diff[DEN_W-1:0] : w_t[DEN_W-1:0];
        n_q.nlo = {i_d.nlo[DIG_STEPS-2:0], 1'b0};
        n_q.quo = {i_d.quo[ROOT_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

/* design/slp_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// slp_sqrt_cell
// One digit-by-digit square root step: one root bit per cell.
// ----------------------------------------------------------------------------
module slp_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_en,
    input  slp_pkg::t_sqr i_d,
    output slp_pkg::t_sqr o_q
);
    import slp_pkg::*;

    logic [REM_W+1:0] w_t;
    logic [REM_W+1:0] w_trial;
    logic [REM_W+1:0] w_diff;
    logic             w_ge;
    t_sqr             n_q;
    t_sqr             r_q;

    assign w_t     = {i_d.rem, i_d.rad[RAD_W-1 -: 2]};
    assign w_trial = {2'b00, i_d.root, 2'b01};
    assign w_diff  = w_t - w_trial;
    assign w_ge    = (w_t >= w_trial);

    always_comb begin
        n_q.rem  = w_ge ? w_diff[REM_W-1:0] : w_t[REM_W-1:0];
        n_q.root = {i_d.root[ROOT_W-2:0], w_ge};
        n_q.rad  = {i_d.rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule
